@@ design/msb_pkg.sv @@
// package for the merge sort buffer
// holds default sizes and the sequencer state type; no dependencies
package msb_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int KEY_WIDTH_DEF = 32;

    // sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RUN_SET,
        ST_MRG_RD,
        ST_MRG_WR,
        ST_OUT_RD,
        ST_OUT_SHOW
    } t_state;

endpackage

@@ design/merge_sort_buffer.sv @@
// merge sort buffer top level: loads keys, sorts by bottom-up merge passes, emits in order
// depends on msb_pkg and msb_ram
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+-----------------------------------
//  input   | i_valid | o_ready | i_key, i_last_in
//  output  | o_valid | i_ready | o_sorted_key, o_last_out, o_overflow
//
// a key is loaded per input handshake; the item flagged last starts the sort of the n stored keys
// each merge pass handles one key at a time (read, then compare and write on one comparator)
// after a run setup state per run pair; ceil(log2(n)) passes ping-pong between two memories
// each result is read, then shown until i_ready takes it, before the next one is read
// o_ready is high only while loading; reset clears counters and flags, memories keep contents
module merge_sort_buffer
    import msb_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [KEY_WIDTH-1:0] i_key,
    input  logic                 i_last_in,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [KEY_WIDTH-1:0] o_sorted_key,
    output logic                 o_last_out,
    output logic                 o_overflow
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = CW + 1;
    localparam int SW = CW + 2;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_dropped, n_dropped;
    logic          r_src, n_src;
    logic [WW-1:0] r_w, n_w;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_k, n_k;

    logic                 s_in_acc, s_out_acc, s_not_full;
    logic [CW-1:0]        s_count_inc;
    logic [SW-1:0]        s_mid_sum, s_hi_sum;
    logic [WW-1:0]        s_w2;
    logic                 s_run_end, s_pass_end, s_sort_done, s_take_left;
    logic [KEY_WIDTH-1:0] s_a, s_b, s_merge_data;
    logic [KEY_WIDTH-1:0] s_rd0_a, s_rd0_b, s_rd1_a, s_rd1_b;
    logic                 s_we0, s_we1;
    logic [AW-1:0]        s_waddr0, s_raddr_a, s_raddr_b;
    logic [KEY_WIDTH-1:0] s_wdata0;

    // handshakes and load bookkeeping
    assign s_in_acc    = i_valid && o_ready;
    assign s_out_acc   = o_valid && i_ready;
    assign s_not_full  = (r_count < CW'(DEPTH));
    assign s_count_inc = s_not_full ? (r_count + CW'(1)) : r_count;

    // run bounds and pass bookkeeping
    assign s_mid_sum   = SW'(r_lo) + SW'(r_w);
    assign s_hi_sum    = SW'(r_lo) + (SW'(r_w) << 1);
    assign s_w2        = {r_w[WW-2:0], 1'b0};
    assign s_run_end   = ((SW'(r_k) + SW'(1)) == SW'(r_hi));
    assign s_pass_end  = (r_hi == r_count);
    assign s_sort_done = (SW'(s_w2) >= SW'(r_count));

    // shared compare unit: stable, left run wins ties
    assign s_a          = r_src ? s_rd1_a : s_rd0_a;
    assign s_b          = r_src ? s_rd1_b : s_rd0_b;
    assign s_take_left  = (r_i < r_mid) &&
                          ((r_j >= r_hi) || ($signed(s_a) <= $signed(s_b)));
    assign s_merge_data = s_take_left ? s_a : s_b;

    // memory ports: loads go to memory 0, merges write the memory that is not the source
    assign s_we0     = (s_in_acc && s_not_full) || ((r_state == ST_MRG_WR) && r_src);
    assign s_we1     = (r_state == ST_MRG_WR) && !r_src;
    assign s_waddr0  = (r_state == ST_LOAD) ? r_count[AW-1:0] : r_k[AW-1:0];
    assign s_wdata0  = (r_state == ST_LOAD) ? i_key : s_merge_data;
    assign s_raddr_a = ((r_state == ST_OUT_RD) || (r_state == ST_OUT_SHOW)) ?
                       r_k[AW-1:0] : r_i[AW-1:0];
    assign s_raddr_b = r_j[AW-1:0];

    msb_ram #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_ram0 (
        .i_clk     (i_clk),
        .i_we      (s_we0),
        .i_waddr   (s_waddr0),
        .i_wdata   (s_wdata0),
        .i_raddr_a (s_raddr_a),
        .i_raddr_b (s_raddr_b),
        .o_rdata_a (s_rd0_a),
        .o_rdata_b (s_rd0_b)
    );

    msb_ram #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_ram1 (
        .i_clk     (i_clk),
        .i_we      (s_we1),
        .i_waddr   (r_k[AW-1:0]),
        .i_wdata   (s_merge_data),
        .i_raddr_a (s_raddr_a),
        .i_raddr_b (s_raddr_b),
        .o_rdata_a (s_rd1_a),
        .o_rdata_b (s_rd1_b)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (s_in_acc && i_last_in) begin
                    n_state = (s_count_inc > CW'(1)) ? ST_RUN_SET : ST_OUT_RD;
                end
            end
            ST_RUN_SET: n_state = ST_MRG_RD;
            ST_MRG_RD:  n_state = ST_MRG_WR;
            ST_MRG_WR: begin
                if (s_run_end) begin
                    n_state = (s_pass_end && s_sort_done) ? ST_OUT_RD : ST_RUN_SET;
                end else begin
                    n_state = ST_MRG_RD;
                end
            end
            ST_OUT_RD:  n_state = ST_OUT_SHOW;
            ST_OUT_SHOW: begin
                if (i_ready) begin
                    n_state = o_last_out ? ST_LOAD : ST_OUT_RD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        o_ready      = (r_state == ST_LOAD);
        o_valid      = (r_state == ST_OUT_SHOW);
        o_sorted_key = s_a;
        o_last_out   = ((SW'(r_k) + SW'(1)) == SW'(r_count));
        o_overflow   = r_dropped;
    end

    // datapath register updates
    always_comb begin
        n_count   = r_count;
        n_dropped = r_dropped;
        n_src     = r_src;
        n_w       = r_w;
        n_lo      = r_lo;
        n_mid     = r_mid;
        n_hi      = r_hi;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        case (r_state)
            ST_LOAD: begin
                if (s_in_acc) begin
                    n_count   = s_count_inc;
                    n_dropped = r_dropped || !s_not_full;
                    n_lo      = '0;
                    n_k       = '0;
                end
            end
            ST_RUN_SET: begin
                n_mid = (s_mid_sum > SW'(r_count)) ? r_count : s_mid_sum[CW-1:0];
                n_hi  = (s_hi_sum > SW'(r_count)) ? r_count : s_hi_sum[CW-1:0];
                n_i   = r_lo;
                n_j   = (s_mid_sum > SW'(r_count)) ? r_count : s_mid_sum[CW-1:0];
                n_k   = r_lo;
            end
            ST_MRG_WR: begin
                n_k = r_k + CW'(1);
                if (s_take_left) begin
                    n_i = r_i + CW'(1);
                end else begin
                    n_j = r_j + CW'(1);
                end
                if (s_run_end) begin
                    n_lo = r_hi;
                    if (s_pass_end) begin
                        n_lo  = '0;
                        n_w   = s_w2;
                        n_src = !r_src;
                        n_k   = '0;
                    end
                end
            end
            ST_OUT_SHOW: begin
                if (s_out_acc) begin
                    n_k = r_k + CW'(1);
                    if (o_last_out) begin
                        n_count   = '0;
                        n_dropped = 1'b0;
                        n_src     = 1'b0;
                        n_w       = WW'(1);
                        n_k       = '0;
                    end
                end
            end
            default: begin
                n_k = r_k;
            end
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_src     <= 1'b0;
            r_w       <= WW'(1);
            r_lo      <= '0;
            r_mid     <= '0;
            r_hi      <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_k       <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_src     <= n_src;
            r_w       <= n_w;
            r_lo      <= n_lo;
            r_mid     <= n_mid;
            r_hi      <= n_hi;
            r_i       <= n_i;
            r_j       <= n_j;
            r_k       <= n_k;
        end
    end

endmodule

@@ design/msb_ram.sv @@
// key memory for the merge sort buffer: one write port, two registered read ports
// depends on msb_pkg for default sizes
module msb_ram
    import msb_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [KEY_WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]        i_raddr_a,
    input  logic [AW-1:0]        i_raddr_b,
    output logic [KEY_WIDTH-1:0] o_rdata_a,
    output logic [KEY_WIDTH-1:0] o_rdata_b
);

    logic [KEY_WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ design/msb_checker.sv @@
// port-level checks for the merge sort buffer, bound to the top level
// depends on msb_pkg for default sizes
module msb_checker
    import msb_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input logic                 i_last_in,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [KEY_WIDTH-1:0] o_sorted_key,
    input logic                 o_last_out,
    input logic                 o_overflow
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_sorted_key) &&
                                   $stable(o_last_out) && $stable(o_overflow)))
        else $error("stalled result changed");

    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input ready while a result is shown");

    // the item flagged last closes the input side
    a_last_in_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_last_in) |=> !o_ready)
        else $error("input still ready after last item");

    // the final result of a set reopens loading
    a_last_out_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_out) |=> (!o_valid && o_ready))
        else $error("block did not return to loading after final result");

endmodule

bind merge_sort_buffer msb_checker #(
    .KEY_WIDTH (KEY_WIDTH)
) u_msb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .i_last_in    (i_last_in),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_sorted_key (o_sorted_key),
    .o_last_out   (o_last_out),
    .o_overflow   (o_overflow)
);
